// ----- design/string_to_integer_parser_macros.svh -----
// Assertion macros for the string-to-integer parser checker.
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef STRING_TO_INTEGER_PARSER_MACROS_SVH
`define STRING_TO_INTEGER_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STIP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("string_to_integer_parser: assertion failed");

// Next-cycle implication, checked outside reset.
`define STIP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("string_to_integer_parser: assertion failed");

`endif

// ----- design/stip_pkg.sv -----
// Shared types and constants of the string-to-integer parser.
// No dependencies; used by the front, queue, back and top-level modules.
package stip_pkg;

    localparam int CH_WIDTH      = 8;
    localparam int VALUE_WIDTH   = 64;
    localparam int OFF_OUT_WIDTH = 16;
    localparam int RADIX_WIDTH   = 6;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [RADIX_WIDTH-1:0] RADIX_RESET  = 6'd10;
    localparam logic [RADIX_WIDTH-1:0] BASE_OCTAL   = 6'd8;
    localparam logic [RADIX_WIDTH-1:0] BASE_DECIMAL = 6'd10;
    localparam logic [RADIX_WIDTH-1:0] BASE_HEX     = 6'd16;
    localparam logic [RADIX_WIDTH-1:0] BASE_DETECT  = 6'd0;

    localparam logic [CH_WIDTH-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CH_WIDTH-1:0] CHAR_TAB     = 8'h09;
    localparam logic [CH_WIDTH-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CH_WIDTH-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CH_WIDTH-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CH_WIDTH-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CH_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CH_WIDTH-1:0] CHAR_UPPER_X = 8'h58;
    localparam logic [CH_WIDTH-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CH_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CH_WIDTH-1:0] CHAR_LOWER_X = 8'h78;
    localparam logic [CH_WIDTH-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CH_WIDTH-1:0] LETTER_BASE  = 8'd10;

    typedef enum logic [2:0] {
        PH_DONE,
        PH_LEAD,
        PH_SIGNED,
        PH_DIGITS,
        PH_HEXMARK
    } phase_t;

    // One classified character as it travels from the front to the back.
    typedef struct packed {
        logic                   first;
        logic                   is_blank;
        logic                   is_sign;
        logic                   is_minus;
        logic                   is_zero;
        logic                   is_x;
        logic                   is_digit;
        logic [RADIX_WIDTH-1:0] dval;
    } item_t;

endpackage

// ----- design/stip_front.sv -----
// Front end of the parser: takes input words and classifies each character.
// Depends on stip_pkg; feeds stip_queue.
module stip_front (
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [stip_pkg::CH_WIDTH-1:0]    ch,
    input  logic                             first,
    input  logic                             q_full,
    output logic                             push,
    output stip_pkg::item_t                  item
);

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb begin
        item          = '0;
        item.first    = first;
        item.is_blank = (ch == stip_pkg::CHAR_SPACE) || (ch == stip_pkg::CHAR_TAB);
        item.is_sign  = (ch == stip_pkg::CHAR_PLUS) || (ch == stip_pkg::CHAR_MINUS);
        item.is_minus = (ch == stip_pkg::CHAR_MINUS);
        item.is_zero  = (ch == stip_pkg::CHAR_ZERO);
        item.is_x     = (ch == stip_pkg::CHAR_LOWER_X) || (ch == stip_pkg::CHAR_UPPER_X);
        case (ch) inside
            [stip_pkg::CHAR_ZERO:stip_pkg::CHAR_NINE]: begin
                item.is_digit = 1'b1;
                item.dval     = stip_pkg::RADIX_WIDTH'(ch - stip_pkg::CHAR_ZERO);
            end
            [stip_pkg::CHAR_LOWER_A:stip_pkg::CHAR_LOWER_Z]: begin
                item.is_digit = 1'b1;
                item.dval     = stip_pkg::RADIX_WIDTH'(ch - stip_pkg::CHAR_LOWER_A
                                                       + stip_pkg::LETTER_BASE);
            end
            [stip_pkg::CHAR_UPPER_A:stip_pkg::CHAR_UPPER_Z]: begin
                item.is_digit = 1'b1;
                item.dval     = stip_pkg::RADIX_WIDTH'(ch - stip_pkg::CHAR_UPPER_A
                                                       + stip_pkg::LETTER_BASE);
            end
            default: begin
                item.is_digit = 1'b0;
                item.dval     = '0;
            end
        endcase
    end

endmodule

// ----- design/stip_queue.sv -----
// Short queue of classified characters between the front and back ends.
// Depends on stip_pkg for the item type and depth.
module stip_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  stip_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output stip_pkg::item_t q_item
);

    localparam int DEPTH = stip_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    stip_pkg::item_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- design/stip_back.sv -----
// Back end of the parser: the sequencer that runs sign, prefix and digit
// handling, the multiply-add accumulator and the output register. Uses stip_pkg.
module stip_back #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic [stip_pkg::RADIX_WIDTH-1:0]        radix,
    input  logic                                    q_valid,
    input  stip_pkg::item_t                         q_item,
    output logic                                    pop,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [stip_pkg::VALUE_WIDTH-1:0]        value,
    output logic [stip_pkg::OFF_OUT_WIDTH-1:0]      end_offset
);

    localparam int VW = stip_pkg::VALUE_WIDTH;
    localparam int RW = stip_pkg::RADIX_WIDTH;

    stip_pkg::phase_t       phase_reg, phase_next, ph;
    logic                   neg_reg, neg_next, neg;
    logic [VW-1:0]          acc_reg, acc_next, acc;
    logic [RW-1:0]          base_reg, base_next, base;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next, pos;
    logic                   zp_reg, zp_next, zp;

    logic                   out_valid_reg, out_valid_next;
    logic [VW-1:0]          out_value_reg, out_value_next;
    logic [OFFSET_BITS-1:0] out_off_reg, out_off_next;

    logic                   emit;
    logic [VW-1:0]          emit_val;
    logic [OFFSET_BITS-1:0] emit_off;
    logic                   out_free;
    logic                   do_begin;
    logic [RW-1:0]          begin_base;

    function automatic logic [OFFSET_BITS-1:0] pos_inc(input logic [OFFSET_BITS-1:0] p);
        pos_inc = (p == '1) ? p : p + 1'b1;
    endfunction

    // A start flag resets the parse before the character is looked at.
    always_comb begin
        ph   = q_item.first ? stip_pkg::PH_LEAD : phase_reg;
        neg  = q_item.first ? 1'b0 : neg_reg;
        acc  = q_item.first ? '0 : acc_reg;
        base = q_item.first ? radix : base_reg;
        pos  = q_item.first ? '0 : pos_reg;
        zp   = q_item.first ? 1'b0 : zp_reg;
    end

    assign do_begin   = (ph == stip_pkg::PH_SIGNED) ||
                        ((ph == stip_pkg::PH_LEAD) && !q_item.is_blank && !q_item.is_sign);
    assign begin_base = (base == stip_pkg::BASE_DETECT) ? stip_pkg::BASE_DECIMAL : base;

    always_comb begin
        phase_next = ph;
        neg_next   = neg;
        acc_next   = acc;
        base_next  = base;
        pos_next   = pos;
        zp_next    = zp;
        emit       = 1'b0;
        emit_val   = '0;
        emit_off   = '0;
        if (do_begin) begin
            if ((base == stip_pkg::BASE_DETECT) && q_item.is_zero) begin
                base_next  = stip_pkg::BASE_OCTAL;
                acc_next   = '0;
                zp_next    = 1'b1;
                phase_next = stip_pkg::PH_DIGITS;
                pos_next   = pos_inc(pos);
            end else begin
                base_next = begin_base;
                if (q_item.is_digit && (q_item.dval < begin_base)) begin
                    acc_next   = VW'(q_item.dval);
                    phase_next = stip_pkg::PH_DIGITS;
                    pos_next   = pos_inc(pos);
                end else begin
                    // No digit at all: the result is zero at the start of the string.
                    acc_next   = '0;
                    phase_next = stip_pkg::PH_DONE;
                    emit       = 1'b1;
                end
            end
        end else begin
            case (ph)
                stip_pkg::PH_LEAD: begin
                    pos_next = pos_inc(pos);
                    if (q_item.is_sign) begin
                        neg_next   = q_item.is_minus;
                        phase_next = stip_pkg::PH_SIGNED;
                    end
                end
                stip_pkg::PH_DIGITS: begin
                    zp_next = 1'b0;
                    if (zp && q_item.is_x) begin
                        // The offset stays at the 'x' until a hex digit confirms it.
                        base_next  = stip_pkg::BASE_HEX;
                        phase_next = stip_pkg::PH_HEXMARK;
                    end else if (q_item.is_digit && (q_item.dval < base)) begin
                        acc_next = acc_reg * VW'(base_reg) + VW'(q_item.dval);
                        pos_next = pos_inc(pos);
                    end else begin
                        phase_next = stip_pkg::PH_DONE;
                        emit       = 1'b1;
                        emit_val   = neg_reg ? ('0 - acc_reg) : acc_reg;
                        emit_off   = pos_reg;
                    end
                end
                stip_pkg::PH_HEXMARK: begin
                    if (q_item.is_digit && (q_item.dval < stip_pkg::BASE_HEX)) begin
                        acc_next   = VW'(q_item.dval);
                        phase_next = stip_pkg::PH_DIGITS;
                        pos_next   = pos_inc(pos_inc(pos));
                    end else begin
                        acc_next   = '0;
                        phase_next = stip_pkg::PH_DONE;
                        emit       = 1'b1;
                        emit_off   = pos_reg;
                    end
                end
                default: begin
                    phase_next = stip_pkg::PH_DONE;
                end
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign pop      = q_valid && (!emit || out_free);

    always_comb begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_off_next   = out_off_reg;
        if (pop && emit) begin
            out_valid_next = 1'b1;
            out_value_next = emit_val;
            out_off_next   = emit_off;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= stip_pkg::PH_DONE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            base_reg      <= '0;
            pos_reg       <= '0;
            zp_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                base_reg  <= base_next;
                pos_reg   <= pos_next;
                zp_reg    <= zp_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_value_reg <= out_value_next;
        out_off_reg   <= out_off_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign value      = out_value_reg;
    assign end_offset = stip_pkg::OFF_OUT_WIDTH'(out_off_reg);

endmodule

// ----- design/string_to_integer_parser.sv -----
// Top level of the streaming string-to-integer parser.
// Instantiates stip_front, stip_queue and stip_back; uses stip_pkg.
//
// Parses a string that arrives one character per word, in the manner of strtol:
// blanks and one sign are skipped, a base of zero picks hex, octal or decimal
// from the prefix, and the first non-digit (or NUL) yields one result word with
// the signed 64-bit value and the offset where parsing stopped. A word with the
// start flag set begins a new string and drops any parse in progress; words
// after a result are ignored until the next start. The block takes one
// character every clock cycle while the queue is not full; the result for the
// character that ends a number goes through the queue and the output register.
// The rate is set by the accumulator loop, one 64 by 6 bit multiply-add per cycle.
// A two-word queue sits between the classifier and the sequencer, so input keeps
// flowing while a result waits to be taken.
// The radix register is read when a string starts and should be written only
// while no string is in flight.
module string_to_integer_parser #(
    parameter int OFFSET_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic [0:0]  s_tuser,   // [0] first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [63:0] value, [79:64] end_offset
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data   // [5:0] radix
);

    logic [stip_pkg::RADIX_WIDTH-1:0]   radix_reg;
    logic                               q_full;
    logic                               push;
    stip_pkg::item_t                    push_item;
    logic                               pop;
    logic                               q_valid;
    stip_pkg::item_t                    q_item;
    logic [stip_pkg::VALUE_WIDTH-1:0]   value;
    logic [stip_pkg::OFF_OUT_WIDTH-1:0] end_offset;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= stip_pkg::RADIX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            radix_reg <= cfg_data;
        end
    end

    stip_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .ch       (s_tdata),
        .first    (s_tuser[0]),
        .q_full   (q_full),
        .push     (push),
        .item     (push_item)
    );

    stip_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    stip_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .radix      (radix_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .value      (value),
        .end_offset (end_offset)
    );

    assign m_tdata = {end_offset, value};

endmodule

// ----- design/stip_checker.sv -----
// Port-level checker for the string-to-integer parser, bound to the top level.
// Depends on string_to_integer_parser_macros.svh.
`include "string_to_integer_parser_macros.svh"

module stip_checker #(
    parameter int OFFSET_BITS = 16
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    // An offset wider than the port can read as zero after masking.
    localparam bit NARROW_OFFSET = (OFFSET_BITS <= 16);

    logic zero_offset;

    assign zero_offset = m_tvalid && (m_tdata[79:64] == 16'd0);

    // A result word held back by the sink must not change.
    `STIP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // An offset of zero means no digit was taken, so the value must be zero.
    `STIP_ASSERT_IMPL(a_zero_offset_zero_value, NARROW_OFFSET && zero_offset, m_tdata[63:0] == 64'd0)

    // With the result side empty now and as sampled by $past, the queue has drained enough to take a word.
    `STIP_ASSERT_IMPL(a_ready_when_drained, !m_tvalid && $past(!m_tvalid), s_tready)

endmodule

bind string_to_integer_parser stip_checker #(
    .OFFSET_BITS (OFFSET_BITS)
) u_stip_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
